[rtl/poi_pkg.sv]
// Shared types, constants and the quarter-wave sine table of the odometry integrator.
`timescale 1ns / 1ps

package poi_pkg;

    // Quarter-wave table resolution
    localparam int TABLE_BITS = 10;
    localparam int QSIZE      = 1 << TABLE_BITS;
    localparam int ROM_AW     = TABLE_BITS + 1;

    // Field widths
    localparam int POS_W = 48;
    localparam int VEL_W = 32;
    localparam int DT_W  = 24;
    localparam int ANG_W = 32;
    localparam int Q_W   = 16;
    localparam int MAG_W = Q_W - 1;

    // Shared multiplier and intermediate widths
    localparam int ROT_W  = VEL_W + 2;
    localparam int TERM_W = ROT_W - 1;
    localparam int MA_W   = ROT_W;
    localparam int MB_W   = DT_W + 1;
    localparam int PROD_W = MA_W + MB_W;
    localparam int ROT_SH = Q_W - 1;
    localparam int DT_SH  = 20;
    localparam int DEL_W  = PROD_W - DT_SH;
    localparam int SUM_W  = POS_W + 2;

    localparam logic [ANG_W-1:0] QUARTER_TURN = {2'b01, {(ANG_W-2){1'b0}}};

    localparam logic signed [POS_W-1:0] POS_MAX = {1'b0, {(POS_W-1){1'b1}}};
    localparam logic signed [POS_W-1:0] POS_MIN = {1'b1, {(POS_W-1){1'b0}}};

    localparam logic signed [VEL_W-1:0] VEL_X_RST    = 32'sd6554;
    localparam logic signed [VEL_W-1:0] VEL_Y_RST    = -32'sd6554;
    localparam logic signed [VEL_W-1:0] YAW_RATE_RST = 32'sd68356528;

    // Register indexes of the configuration port
    localparam int CFG_AW = 2;
    localparam logic [CFG_AW-1:0] CFG_VEL_X    = 2'd0;
    localparam logic [CFG_AW-1:0] CFG_VEL_Y    = 2'd1;
    localparam logic [CFG_AW-1:0] CFG_YAW_RATE = 2'd2;

    localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

    typedef enum logic [1:0] {
        ROM_COS_OLD  = 2'd0,
        ROM_SIN_OLD  = 2'd1,
        ROM_SIN_HALF = 2'd2,
        ROM_COS_HALF = 2'd3
    } t_rom_sel;

    typedef enum logic [2:0] {
        MUL_YAW_DT = 3'd0,
        MUL_VX_C   = 3'd1,
        MUL_VY_S   = 3'd2,
        MUL_VX_S   = 3'd3,
        MUL_VY_C   = 3'd4,
        MUL_RX_DT  = 3'd5,
        MUL_RY_DT  = 3'd6
    } t_mul_sel;

    typedef struct packed {
        logic     load_dt;
        t_rom_sel rom_sel;
        t_mul_sel mul_sel;
        logic     ld_c;
        logic     ld_s;
        logic     ld_head;
        logic     ld_rx_init;
        logic     ld_rx_sub;
        logic     ld_ry_init;
        logic     ld_ry_add;
        logic     ld_qz;
        logic     ld_qw;
        logic     ld_px;
        logic     ld_py;
        logic     commit;
    } t_cmd;

    typedef logic [MAG_W-1:0] t_sine_rom [0:QSIZE];

    // Restoring long division, only evaluated while the table is built
    function automatic logic [63:0] f_udiv64(input logic [63:0] num, input logic [63:0] den);
        logic [63:0] q;
        logic [64:0] rem;
        int          i;
        q   = '0;
        rem = '0;
        for (i = 63; i >= 0; i--) begin
            rem = {rem[63:0], num[i]};
            if (rem >= {1'b0, den}) begin
                rem  = rem - {1'b0, den};
                q[i] = 1'b1;
            end
        end
        return q;
    endfunction

    // Taylor series in Q30, round half up to Q1.15, clamp at full scale
    function automatic t_sine_rom f_build_sine();
        t_sine_rom   rom;
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] term;
        logic [63:0] den;
        longint      sum;
        longint      r;
        int          k;
        int          n;
        for (k = 0; k <= QSIZE; k++) begin
            x    = (HALF_PI_Q30 * 64'(k)) >> TABLE_BITS;
            x2   = (x * x) >> 30;
            term = x;
            sum  = longint'(x);
            n    = 1;
            while (term != 0 && n < 40) begin
                den  = 64'(2 * n) * 64'(2 * n + 1);
                term = f_udiv64((term * x2) >> 30, den);
                if (n[0]) begin
                    sum = sum - longint'(term);
                end else begin
                    sum = sum + longint'(term);
                end
                n++;
            end
            if (sum < 0) begin
                sum = 0;
            end
            r = (sum + 64'sd16384) >>> 15;
            if (r > 32767) begin
                r = 32767;
            end
            rom[k] = MAG_W'(r);
        end
        return rom;
    endfunction

    localparam t_sine_rom SINE_ROM = f_build_sine();

endpackage

[rtl/planar_odometry_integrator_top.sv]
// Top level of the planar odometry integrator: sequencer plus datapath.
`timescale 1ns / 1ps

// Each accepted elapsed-time word advances the pose: the body velocities are
// rotated by the heading held before the update, scaled by the interval and
// added to the saturating 48-bit position; yaw rate times the interval is added
// to the wrapping 32-bit heading; the output word carries the new position,
// heading and the Q1.15 yaw quaternion. A new word is not taken until the
// previous update is done, as the single shared 34x25 multiplier forms the
// seven products of an update in sequence, interleaved with four registered
// reads of the quarter-wave sine table. The next word is accepted as soon as
// the result has moved into the output register, even while that result is
// still stalled; configuration writes should be made while idle.

module planar_odometry_integrator_top import poi_pkg::*; (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_cfg_we,
    input  logic [CFG_AW-1:0]       i_cfg_idx,
    input  logic [VEL_W-1:0]        i_cfg_data,
    input  logic                    i_valid,
    output logic                    o_stall,
    input  logic [DT_W-1:0]         i_elapsed,
    output logic                    o_valid,
    input  logic                    i_stall,
    output logic signed [POS_W-1:0] o_pos_x,
    output logic signed [POS_W-1:0] o_pos_y,
    output logic [ANG_W-1:0]        o_heading,
    output logic signed [Q_W-1:0]   o_quat_z,
    output logic signed [Q_W-1:0]   o_quat_w
);

    t_cmd w_cmd;

    poi_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_cmd   (w_cmd)
    );

    poi_dp u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_elapsed  (i_elapsed),
        .i_cmd      (w_cmd),
        .o_pos_x    (o_pos_x),
        .o_pos_y    (o_pos_y),
        .o_heading  (o_heading),
        .o_quat_z   (o_quat_z),
        .o_quat_w   (o_quat_w)
    );

    // a result is only written into a free output register
    a_commit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.commit |-> (!o_valid || !i_stall))
        else $error("result committed over an untaken word");

    // an accepted word makes the block busy on the next cycle
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> o_stall)
        else $error("block not busy after accepting a word");

    // a new output word appears only after a commit
    a_valid_rise: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(w_cmd.commit))
        else $error("output valid rose without a commit");

    // stored pose changes only on a commit
    a_state_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !$past(w_cmd.commit) && $past(i_rst_n) |-> $stable(o_heading) && $stable(o_pos_x))
        else $error("pose changed outside a commit");

endmodule

[rtl/poi_ctrl.sv]
// Sequencer that steps the shared multiplier and sine table through one update.
`timescale 1ns / 1ps

module poi_ctrl import poi_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_stall,
    output logic o_valid,
    input  logic i_stall,
    output t_cmd o_cmd
);

    typedef enum logic [9:0] {
        ST_IDLE = 10'b00_0000_0001,
        ST_RATE = 10'b00_0000_0010,
        ST_HEAD = 10'b00_0000_0100,
        ST_RX0  = 10'b00_0000_1000,
        ST_RX1  = 10'b00_0001_0000,
        ST_RY0  = 10'b00_0010_0000,
        ST_RY1  = 10'b00_0100_0000,
        ST_PX   = 10'b00_1000_0000,
        ST_PY   = 10'b01_0000_0000,
        ST_DONE = 10'b10_0000_0000
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   w_out_free;

    assign w_out_free = !r_out_valid || !i_stall;

    always_comb begin
        n_state          = r_state;
        o_cmd            = '0;
        o_cmd.rom_sel    = ROM_SIN_OLD;
        o_cmd.mul_sel    = MUL_YAW_DT;
        unique case (r_state)
            ST_IDLE: begin
                o_cmd.rom_sel = ROM_COS_OLD;
                if (i_valid) begin
                    o_cmd.load_dt = 1'b1;
                    n_state       = ST_RATE;
                end
            end
            ST_RATE: begin
                o_cmd.ld_c    = 1'b1;
                o_cmd.rom_sel = ROM_SIN_OLD;
                o_cmd.mul_sel = MUL_YAW_DT;
                n_state       = ST_HEAD;
            end
            ST_HEAD: begin
                o_cmd.ld_s    = 1'b1;
                o_cmd.ld_head = 1'b1;
                o_cmd.mul_sel = MUL_VX_C;
                n_state       = ST_RX0;
            end
            ST_RX0: begin
                o_cmd.ld_rx_init = 1'b1;
                o_cmd.mul_sel    = MUL_VY_S;
                o_cmd.rom_sel    = ROM_SIN_HALF;
                n_state          = ST_RX1;
            end
            ST_RX1: begin
                o_cmd.ld_rx_sub = 1'b1;
                o_cmd.ld_qz     = 1'b1;
                o_cmd.mul_sel   = MUL_VX_S;
                o_cmd.rom_sel   = ROM_COS_HALF;
                n_state         = ST_RY0;
            end
            ST_RY0: begin
                o_cmd.ld_ry_init = 1'b1;
                o_cmd.ld_qw      = 1'b1;
                o_cmd.mul_sel    = MUL_VY_C;
                n_state          = ST_RY1;
            end
            ST_RY1: begin
                o_cmd.ld_ry_add = 1'b1;
                o_cmd.mul_sel   = MUL_RX_DT;
                n_state         = ST_PX;
            end
            ST_PX: begin
                o_cmd.ld_px   = 1'b1;
                o_cmd.mul_sel = MUL_RY_DT;
                n_state       = ST_PY;
            end
            ST_PY: begin
                o_cmd.ld_py = 1'b1;
                n_state     = ST_DONE;
            end
            ST_DONE: begin
                // hold until the output register can take the new word
                if (w_out_free) begin
                    o_cmd.commit = 1'b1;
                    n_state      = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.commit) begin
            n_out_valid = 1'b1;
        end else if (r_out_valid && !i_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_stall = (r_state != ST_IDLE);
    assign o_valid = r_out_valid;

endmodule

[rtl/poi_dp.sv]
// Datapath: configuration registers, sine table, shared multiplier and pose state.
`timescale 1ns / 1ps

module poi_dp import poi_pkg::*; (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_cfg_we,
    input  logic [CFG_AW-1:0]       i_cfg_idx,
    input  logic [VEL_W-1:0]        i_cfg_data,
    input  logic [DT_W-1:0]         i_elapsed,
    input  t_cmd                    i_cmd,
    output logic signed [POS_W-1:0] o_pos_x,
    output logic signed [POS_W-1:0] o_pos_y,
    output logic [ANG_W-1:0]        o_heading,
    output logic signed [Q_W-1:0]   o_quat_z,
    output logic signed [Q_W-1:0]   o_quat_w
);

    logic signed [VEL_W-1:0]  r_vel_x;
    logic signed [VEL_W-1:0]  r_vel_y;
    logic signed [VEL_W-1:0]  r_yaw_rate;

    logic [DT_W-1:0]          r_dt;
    logic signed [Q_W-1:0]    r_c;
    logic signed [Q_W-1:0]    r_s;
    logic [ANG_W-1:0]         r_new_head;
    logic signed [ROT_W-1:0]  r_rx;
    logic signed [ROT_W-1:0]  r_ry;
    logic signed [POS_W-1:0]  r_px;
    logic signed [POS_W-1:0]  r_py;
    logic signed [Q_W-1:0]    r_qz;
    logic signed [Q_W-1:0]    r_qw;

    // position and heading state double as the output words
    logic signed [POS_W-1:0]  r_pos_x;
    logic signed [POS_W-1:0]  r_pos_y;
    logic [ANG_W-1:0]         r_heading;
    logic signed [Q_W-1:0]    r_quat_z;
    logic signed [Q_W-1:0]    r_quat_w;

    logic [MAG_W-1:0]         r_rom_mag;
    logic                     r_rom_neg;
    logic signed [PROD_W-1:0] r_prod;

    logic [ANG_W-1:0]         w_half;
    logic [ANG_W-1:0]         w_angle;
    logic [TABLE_BITS-1:0]    w_idx;
    logic [ROM_AW-1:0]        w_addr;
    logic signed [Q_W-1:0]    w_rom_val;
    logic signed [MA_W-1:0]   w_mul_a;
    logic signed [MB_W-1:0]   w_mul_b;
    logic signed [MB_W-1:0]   w_dt;
    logic signed [TERM_W-1:0] w_term;
    logic signed [DEL_W-1:0]  w_del;
    logic signed [SUM_W-1:0]  w_sum_x;
    logic signed [SUM_W-1:0]  w_sum_y;

    function automatic logic signed [POS_W-1:0] f_sat(input logic signed [SUM_W-1:0] v);
        if (v > SUM_W'(POS_MAX)) begin
            return POS_MAX;
        end else if (v < SUM_W'(POS_MIN)) begin
            return POS_MIN;
        end
        return v[POS_W-1:0];
    endfunction

    // table address: fold the quadrant onto the quarter wave
    assign w_half = r_new_head >> 1;

    always_comb begin
        unique case (i_cmd.rom_sel)
            ROM_COS_OLD:  w_angle = r_heading + QUARTER_TURN;
            ROM_SIN_OLD:  w_angle = r_heading;
            ROM_SIN_HALF: w_angle = w_half;
            ROM_COS_HALF: w_angle = w_half + QUARTER_TURN;
            default:      w_angle = r_heading;
        endcase
    end

    assign w_idx  = w_angle[ANG_W-3 -: TABLE_BITS];
    assign w_addr = w_angle[ANG_W-2] ? (ROM_AW'(QSIZE) - {1'b0, w_idx}) : {1'b0, w_idx};

    assign w_rom_val = r_rom_neg ? -$signed({1'b0, r_rom_mag}) : $signed({1'b0, r_rom_mag});

    // shared multiplier operands
    assign w_dt = $signed({1'b0, r_dt});

    always_comb begin
        unique case (i_cmd.mul_sel)
            MUL_YAW_DT: begin
                w_mul_a = MA_W'(r_yaw_rate);
                w_mul_b = w_dt;
            end
            MUL_VX_C: begin
                w_mul_a = MA_W'(r_vel_x);
                w_mul_b = MB_W'(r_c);
            end
            MUL_VY_S: begin
                w_mul_a = MA_W'(r_vel_y);
                w_mul_b = MB_W'(r_s);
            end
            MUL_VX_S: begin
                w_mul_a = MA_W'(r_vel_x);
                w_mul_b = MB_W'(r_s);
            end
            MUL_VY_C: begin
                w_mul_a = MA_W'(r_vel_y);
                w_mul_b = MB_W'(r_c);
            end
            MUL_RX_DT: begin
                w_mul_a = r_rx;
                w_mul_b = w_dt;
            end
            MUL_RY_DT: begin
                w_mul_a = r_ry;
                w_mul_b = w_dt;
            end
            default: begin
                w_mul_a = '0;
                w_mul_b = '0;
            end
        endcase
    end

    // floor shifts are plain drops of the low product bits
    assign w_term  = $signed(r_prod[ROT_SH +: TERM_W]);
    assign w_del   = $signed(r_prod[PROD_W-1:DT_SH]);
    assign w_sum_x = SUM_W'(r_pos_x) + SUM_W'(w_del);
    assign w_sum_y = SUM_W'(r_pos_y) + SUM_W'(w_del);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vel_x    <= VEL_X_RST;
            r_vel_y    <= VEL_Y_RST;
            r_yaw_rate <= YAW_RATE_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_VEL_X:    r_vel_x    <= $signed(i_cfg_data);
                CFG_VEL_Y:    r_vel_y    <= $signed(i_cfg_data);
                CFG_YAW_RATE: r_yaw_rate <= $signed(i_cfg_data);
                default: begin
                    // drop writes to unknown indexes
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos_x   <= '0;
            r_pos_y   <= '0;
            r_heading <= '0;
        end else if (i_cmd.commit) begin
            r_pos_x   <= r_px;
            r_pos_y   <= r_py;
            r_heading <= r_new_head;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rom_mag <= SINE_ROM[w_addr];
        r_rom_neg <= w_angle[ANG_W-1];
        r_prod    <= w_mul_a * w_mul_b;
        if (i_cmd.load_dt) begin
            r_dt <= i_elapsed;
        end
        if (i_cmd.ld_c) begin
            r_c <= w_rom_val;
        end
        if (i_cmd.ld_s) begin
            r_s <= w_rom_val;
        end
        if (i_cmd.ld_head) begin
            r_new_head <= r_heading + r_prod[DT_SH +: ANG_W];
        end
        if (i_cmd.ld_rx_init) begin
            r_rx <= ROT_W'(w_term);
        end
        if (i_cmd.ld_rx_sub) begin
            r_rx <= r_rx - ROT_W'(w_term);
        end
        if (i_cmd.ld_ry_init) begin
            r_ry <= ROT_W'(w_term);
        end
        if (i_cmd.ld_ry_add) begin
            r_ry <= r_ry + ROT_W'(w_term);
        end
        if (i_cmd.ld_qz) begin
            r_qz <= w_rom_val;
        end
        if (i_cmd.ld_qw) begin
            r_qw <= w_rom_val;
        end
        if (i_cmd.ld_px) begin
            r_px <= f_sat(w_sum_x);
        end
        if (i_cmd.ld_py) begin
            r_py <= f_sat(w_sum_y);
        end
        if (i_cmd.commit) begin
            r_quat_z <= r_qz;
            r_quat_w <= r_qw;
        end
    end

    assign o_pos_x   = r_pos_x;
    assign o_pos_y   = r_pos_y;
    assign o_heading = r_heading;
    assign o_quat_z  = r_quat_z;
    assign o_quat_w  = r_quat_w;

endmodule

[tb/testbench.sv]
// Self-checking testbench of the planar odometry integrator: pose prediction, random traffic.
`timescale 1ns / 1ps

module testbench;
    import poi_pkg::*;

    localparam logic [CFG_AW-1:0] CFG_UNUSED = 2'd3;
    localparam longint unsigned RIGHT_ANGLE_Q30 = 64'd1686629713;
    localparam longint SAT_HI = 64'sd140737488355327;
    localparam longint SAT_LO = -64'sd140737488355328;
    localparam logic [ANG_W-1:0] QUARTER = 32'h4000_0000;
    localparam int SETTLE_CYCLES  = 12;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int RANDOM_WORDS   = 1350;
    localparam int TAIL_WORDS     = 100;

    typedef struct {
        logic signed [POS_W-1:0] pos_x;
        logic signed [POS_W-1:0] pos_y;
        logic [ANG_W-1:0]        heading;
        logic signed [Q_W-1:0]   quat_z;
        logic signed [Q_W-1:0]   quat_w;
    } t_pose;

    logic                    i_clk = 1'b0;
    logic                    i_rst_n = 1'b0;
    logic                    i_cfg_we = 1'b0;
    logic [CFG_AW-1:0]       i_cfg_idx = '0;
    logic [VEL_W-1:0]        i_cfg_data = '0;
    logic                    i_valid = 1'b0;
    logic [DT_W-1:0]         i_elapsed = '0;
    logic                    i_stall = 1'b0;
    logic                    o_stall;
    logic                    o_valid;
    logic signed [POS_W-1:0] o_pos_x;
    logic signed [POS_W-1:0] o_pos_y;
    logic [ANG_W-1:0]        o_heading;
    logic signed [Q_W-1:0]   o_quat_z;
    logic signed [Q_W-1:0]   o_quat_w;

    // predicted pose and register copies
    longint           track_x;
    longint           track_y;
    logic [ANG_W-1:0] track_yaw;
    longint           cfg_vel_x;
    longint           cfg_vel_y;
    longint           cfg_yaw_rate;
    longint           quarter_sine [0:QSIZE];

    logic [DT_W-1:0] elapsed_pending [$];
    t_pose           expected_poses [$];
    t_pose           want;

    int errors = 0;
    int idle_cycles = 0;
    int gap_left = 0;
    int stall_left = 0;
    int in_gap_pct = 0;
    int out_stall_pct = 0;
    bit word_sent = 1'b0;

    planar_odometry_integrator_top dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_valid    (i_valid),
        .o_stall    (o_stall),
        .i_elapsed  (i_elapsed),
        .o_valid    (o_valid),
        .i_stall    (i_stall),
        .o_pos_x    (o_pos_x),
        .o_pos_y    (o_pos_y),
        .o_heading  (o_heading),
        .o_quat_z   (o_quat_z),
        .o_quat_w   (o_quat_w)
    );

    always #4 i_clk = ~i_clk;

    // Taylor series of the quarter wave in Q30, rounded half up to Q1.15
    function automatic void build_quarter_sine();
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] term;
        longint      sum;
        longint      r;
        int          k;
        int          n;
        for (k = 0; k <= QSIZE; k++) begin
            x    = (RIGHT_ANGLE_Q30 * 64'(k)) >> TABLE_BITS;
            x2   = (x * x) >> 30;
            term = x;
            sum  = longint'(x);
            n    = 1;
            while (term != 0 && n < 40) begin
                term = ((term * x2) >> 30) / (64'(2 * n) * 64'(2 * n + 1));
                if (n[0]) begin
                    sum = sum - longint'(term);
                end else begin
                    sum = sum + longint'(term);
                end
                n++;
            end
            if (sum < 0) begin
                sum = 0;
            end
            r = (sum + 64'sd16384) >>> 15;
            if (r > 32767) begin
                r = 32767;
            end
            quarter_sine[k] = r;
        end
    endfunction

    function automatic longint sine_q15(input logic [ANG_W-1:0] angle);
        logic [1:0] quad;
        int         idx;
        longint     mag;
        quad = angle[31:30];
        idx  = int'(angle[29 -: TABLE_BITS]);
        mag  = quad[0] ? quarter_sine[QSIZE - idx] : quarter_sine[idx];
        return quad[1] ? -mag : mag;
    endfunction

    function automatic longint clamp_pos(input longint v);
        if (v > SAT_HI) begin
            return SAT_HI;
        end
        if (v < SAT_LO) begin
            return SAT_LO;
        end
        return v;
    endfunction

    // Rotate by the old heading, integrate, then turn
    function automatic t_pose advance_pose(input logic [DT_W-1:0] elapsed);
        longint           dt;
        longint           c;
        longint           s;
        longint           rx;
        longint           ry;
        longint           dth;
        logic [ANG_W-1:0] half;
        t_pose            p;
        dt  = longint'({40'd0, elapsed});
        c   = sine_q15(track_yaw + QUARTER);
        s   = sine_q15(track_yaw);
        rx  = ((cfg_vel_x * c) >>> 15) - ((cfg_vel_y * s) >>> 15);
        ry  = ((cfg_vel_x * s) >>> 15) + ((cfg_vel_y * c) >>> 15);
        track_x = clamp_pos(track_x + ((rx * dt) >>> 20));
        track_y = clamp_pos(track_y + ((ry * dt) >>> 20));
        dth = (cfg_yaw_rate * dt) >>> 20;
        track_yaw = track_yaw + dth[31:0];
        half = track_yaw >> 1;
        p.pos_x   = track_x[POS_W-1:0];
        p.pos_y   = track_y[POS_W-1:0];
        p.heading = track_yaw;
        p.quat_z  = Q_W'(sine_q15(half));
        p.quat_w  = Q_W'(sine_q15(half + QUARTER));
        return p;
    endfunction

    function automatic logic [DT_W-1:0] pick_elapsed();
        case ($urandom_range(9))
            0: return ($urandom_range(1) != 0) ? 24'hFF_FFFF : 24'd0;
            1, 2, 3: return DT_W'($urandom_range(0, 65535));
            4: return DT_W'($urandom_range(0, 24'hF_FFFF));
            default: return DT_W'($urandom());
        endcase
    endfunction

    function automatic logic [VEL_W-1:0] pick_reg_value();
        case ($urandom_range(7))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return 32'd0;
            3: return VEL_W'($urandom_range(0, 2097152)) - 32'd1048576;
            default: return $urandom();
        endcase
    endfunction

    function automatic int pick_pct();
        case ($urandom_range(3))
            0: return 0;
            1: return 10;
            2: return 30;
            default: return 60;
        endcase
    endfunction

    task automatic write_reg(input logic [CFG_AW-1:0] idx, input logic [VEL_W-1:0] data);
        @(negedge i_clk);
        i_cfg_we   = 1'b1;
        i_cfg_idx  = idx;
        i_cfg_data = data;
        case (idx)
            CFG_VEL_X:    cfg_vel_x = $signed(data);
            CFG_VEL_Y:    cfg_vel_y = $signed(data);
            CFG_YAW_RATE: cfg_yaw_rate = $signed(data);
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_we = 1'b0;
    endtask

    // Hold until every queued word is taken and every pose has come back
    task automatic wait_drained();
        while (elapsed_pending.size() != 0 || i_valid || expected_poses.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // sender
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else if (!i_valid || word_sent) begin
            if (gap_left > 0) begin
                gap_left--;
                i_valid <= 1'b0;
            end else if (elapsed_pending.size() != 0 && in_gap_pct > 0 &&
                         $urandom_range(99) < in_gap_pct) begin
                gap_left = $urandom_range(1, 13) - 1;
                i_valid <= 1'b0;
            end else if (elapsed_pending.size() != 0) begin
                i_valid   <= 1'b1;
                i_elapsed <= elapsed_pending.pop_front();
            end else begin
                i_valid <= 1'b0;
            end
        end
        word_sent = 1'b0;
    end

    // receiver back-pressure
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left--;
            i_stall <= 1'b1;
        end else if (out_stall_pct > 0 && $urandom_range(99) < out_stall_pct) begin
            stall_left = $urandom_range(1, 13) - 1;
            i_stall <= 1'b1;
        end else begin
            i_stall <= 1'b0;
        end
    end

    // accept, predict and check
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_valid && !o_stall) begin
                expected_poses.push_back(advance_pose(i_elapsed));
                word_sent = 1'b1;
            end
            if (o_valid && !i_stall) begin
                if (expected_poses.size() == 0) begin
                    $error("pose word with no expectation waiting");
                    errors++;
                end else begin
                    want = expected_poses.pop_front();
                    if (o_pos_x !== want.pos_x) begin
                        $error("pos_x: expected %0d, got %0d", want.pos_x, o_pos_x);
                        errors++;
                    end
                    if (o_pos_y !== want.pos_y) begin
                        $error("pos_y: expected %0d, got %0d", want.pos_y, o_pos_y);
                        errors++;
                    end
                    if (o_heading !== want.heading) begin
                        $error("heading: expected %0h, got %0h", want.heading, o_heading);
                        errors++;
                    end
                    if (o_quat_z !== want.quat_z) begin
                        $error("quat_z: expected %0d, got %0d", want.quat_z, o_quat_z);
                        errors++;
                    end
                    if (o_quat_w !== want.quat_w) begin
                        $error("quat_w: expected %0d, got %0d", want.quat_w, o_quat_w);
                        errors++;
                    end
                end
            end
            if ((i_valid && !o_stall) || (o_valid && !i_stall) || i_cfg_we) begin
                idle_cycles <= 0;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

    initial begin
        wait (idle_cycles >= WATCHDOG_LIMIT);
        $display("planar_odometry_integrator_top test failed");
        $finish;
    end

    initial begin
        int random_words;
        int n;
        random_words = 0;
        build_quarter_sine();
        track_x      = 0;
        track_y      = 0;
        track_yaw    = '0;
        cfg_vel_x    = 6554;
        cfg_vel_y    = -6554;
        cfg_yaw_rate = 68356528;

        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed: reset settings, field extremes, zero interval
        in_gap_pct    = 30;
        out_stall_pct = 30;
        elapsed_pending = '{24'd0, 24'd1, 24'hFF_FFFF, 24'h80_0000, 24'h55_5555,
                            24'hAA_AAAA, 24'd0};
        wait_drained();

        // ignored index, then register extremes with heading wrap
        write_reg(CFG_UNUSED, $urandom());
        write_reg(CFG_VEL_X, 32'h7FFF_FFFF);
        write_reg(CFG_VEL_Y, 32'h8000_0000);
        write_reg(CFG_YAW_RATE, 32'h8000_0000);
        elapsed_pending = '{24'hFF_FFFF, 24'hFF_FFFF, 24'd0};
        wait_drained();

        write_reg(CFG_VEL_X, 32'h8000_0000);
        write_reg(CFG_VEL_Y, 32'h7FFF_FFFF);
        write_reg(CFG_YAW_RATE, 32'h7FFF_FFFF);
        elapsed_pending = '{24'hFF_FFFF, 24'hFF_FFFF, 24'd1};
        wait_drained();

        // exact quarter turns: quadrant edges and the quaternion sign flip at wrap
        write_reg(CFG_VEL_X, 32'd0);
        write_reg(CFG_VEL_Y, 32'd0);
        write_reg(CFG_YAW_RATE, 32'h4000_0000);
        elapsed_pending = '{24'h10_0000, 24'h10_0000, 24'h10_0000, 24'h10_0000};
        wait_drained();

        write_reg(CFG_VEL_X, 32'd1);
        write_reg(CFG_VEL_Y, 32'hFFFF_FFFF);
        write_reg(CFG_YAW_RATE, 32'd0);
        elapsed_pending = '{24'd1, 24'hFF_FFFF};
        wait_drained();

        // random phases, settings change only while drained
        while (random_words < RANDOM_WORDS) begin
            if ($urandom_range(2) != 0) write_reg(CFG_VEL_X, pick_reg_value());
            if ($urandom_range(2) != 0) write_reg(CFG_VEL_Y, pick_reg_value());
            if ($urandom_range(2) != 0) write_reg(CFG_YAW_RATE, pick_reg_value());
            if ($urandom_range(7) == 0) write_reg(CFG_UNUSED, $urandom());
            in_gap_pct    = pick_pct();
            out_stall_pct = pick_pct();
            n = $urandom_range(20, 150);
            repeat (n) elapsed_pending.push_back(pick_elapsed());
            random_words += n;
            wait_drained();
        end

        // closing stretch at full speed on both sides
        write_reg(CFG_VEL_X, pick_reg_value());
        write_reg(CFG_VEL_Y, pick_reg_value());
        write_reg(CFG_YAW_RATE, pick_reg_value());
        in_gap_pct    = 0;
        out_stall_pct = 0;
        repeat (TAIL_WORDS) elapsed_pending.push_back(pick_elapsed());
        wait_drained();

        if (errors == 0) begin
            $display("planar_odometry_integrator_top test passed");
        end else begin
            $display("planar_odometry_integrator_top test failed");
        end
        $finish;
    end

endmodule
